>>> design/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

  // Fixed widths of the item fields.
  localparam int ByteW  = 8;
  localparam int TimerW = 16;
  localparam int WordW  = 2 * ByteW;

  // Reply sequence upper end and the run of zero bytes that ends a session.
  localparam logic [ByteW-1:0] ReplyLast = 8'hBF;
  localparam logic [1:0]       ZeroLimit = 2'd3;

  // Configuration register reset values.
  localparam logic [ByteW-1:0]  StartByteRst   = 8'd170;
  localparam logic [ByteW-1:0]  AckByteRst     = 8'd172;
  localparam logic [ByteW-1:0]  ToggleByteRst  = 8'd204;
  localparam logic [ByteW-1:0]  ReplyFirstRst  = 8'd176;
  localparam logic [TimerW-1:0] ReplyDelayRst  = 16'd3000;
  localparam logic [TimerW-1:0] IdleTimeoutRst = 16'd4000;
  localparam logic [TimerW-1:0] LedPulseRst    = 16'd50;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_BYTE   = 3'd0,
    REG_ACK_BYTE     = 3'd1,
    REG_TOGGLE_BYTE  = 3'd2,
    REG_REPLY_FIRST  = 3'd3,
    REG_REPLY_DELAY  = 3'd4,
    REG_IDLE_TIMEOUT = 3'd5,
    REG_LED_PULSE    = 3'd6
  } cfg_reg_t;

  // Session phases.
  localparam logic [1:0] PhaseWaitStart = 2'd0;
  localparam logic [1:0] PhaseWaitByte  = 2'd1;
  localparam logic [1:0] PhaseWaitReply = 2'd2;
  localparam logic [1:0] PhaseBad       = 2'd3;

  // Session reset causes.
  localparam logic [1:0] CauseNone       = 2'd0;
  localparam logic [1:0] CauseZeros      = 2'd1;
  localparam logic [1:0] CauseIdle       = 2'd2;
  localparam logic [1:0] CauseReplyIdle  = 2'd3;

  // Item modes.
  localparam logic ModeTick = 1'b0;
  localparam logic ModeByte = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic             line_valid;
    logic [ByteW-1:0] line_byte;
    logic             last;
    logic             rx_led;
    logic             tx_led;
    logic [1:0]       phase;
    logic [1:0]       reset_cause;
    logic             bad_word;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  open_code;
    logic [ByteW-1:0]  ack_code;
    logic [ByteW-1:0]  toggle_byte;
    logic [ByteW-1:0]  reply_first;
    logic [TimerW-1:0] reply_wait_ticks;
    logic [TimerW-1:0] idle_timeout_ms;
    logic [TimerW-1:0] led_pulse_ms;
  } cfg_t;

  // Outcome of one step, handed to the output queue.
  typedef struct packed {
    logic             tx_have;
    logic [WordW-1:0] tx_word;
    logic             rx_led;
    logic             tx_led;
    logic [1:0]       phase;
    logic [1:0]       cause;
    logic             bad;
  } step_res_t;

  // Manchester encode, MSB first: data 1 is line 01, data 0 is line 10.
  function automatic logic [WordW-1:0] mch_encode(input logic [ByteW-1:0] v);
    logic [WordW-1:0] w;
    w = '0;
    for (int i = 0; i < ByteW; i++) begin
      w[2*i+1] = ~v[i];
      w[2*i]   = v[i];
    end
    return w;
  endfunction

  // True when every bit pair of the word is 01 or 10.
  function automatic logic mch_valid(input logic [WordW-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < ByteW; i++) begin
      ok = ok & (w[2*i+1] ^ w[2*i]);
    end
    return ok;
  endfunction

  // Data bits are the low bit of each pair.
  function automatic logic [ByteW-1:0] mch_decode(input logic [WordW-1:0] w);
    logic [ByteW-1:0] v;
    v = '0;
    for (int i = 0; i < ByteW; i++) begin
      v[i] = w[2*i];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/mlr_cfg.sv
`default_nettype none

module mlr_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [2:0]            wr_index,
  input  wire logic [15:0]           wr_data,
  output mlr_pkg::cfg_t              cfg
);

  // Register file; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_code        <= mlr_pkg::StartByteRst;
      cfg.ack_code         <= mlr_pkg::AckByteRst;
      cfg.toggle_byte      <= mlr_pkg::ToggleByteRst;
      cfg.reply_first      <= mlr_pkg::ReplyFirstRst;
      cfg.reply_wait_ticks <= mlr_pkg::ReplyDelayRst;
      cfg.idle_timeout_ms  <= mlr_pkg::IdleTimeoutRst;
      cfg.led_pulse_ms     <= mlr_pkg::LedPulseRst;
    end else if (wr_en) begin
      unique case (wr_index)
        mlr_pkg::REG_START_BYTE:   cfg.open_code        <= wr_data[7:0];
        mlr_pkg::REG_ACK_BYTE:     cfg.ack_code         <= wr_data[7:0];
        mlr_pkg::REG_TOGGLE_BYTE:  cfg.toggle_byte      <= wr_data[7:0];
        mlr_pkg::REG_REPLY_FIRST:  cfg.reply_first      <= wr_data[7:0];
        mlr_pkg::REG_REPLY_DELAY:  cfg.reply_wait_ticks <= wr_data;
        mlr_pkg::REG_IDLE_TIMEOUT: cfg.idle_timeout_ms  <= wr_data;
        mlr_pkg::REG_LED_PULSE:    cfg.led_pulse_ms     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/mlr_step.sv
`default_nettype none

module mlr_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire mlr_pkg::in_item_t item,
  input  wire mlr_pkg::cfg_t     cfg,
  output mlr_pkg::step_res_t     res
);

  // Session state.
  logic [1:0]  session_phase, session_phase_next;
  logic        half_pending, half_pending_next;
  logic [7:0]  half_word, half_word_next;
  logic [7:0]  next_reply, next_reply_next;
  logic [1:0]  zero_run, zero_run_next;
  logic [15:0] reply_wait_left, reply_wait_left_next;
  logic [15:0] idle_left, idle_left_next;
  logic [15:0] rx_pulse_left, rx_pulse_left_next;
  logic [15:0] tx_pulse_left, tx_pulse_left_next;
  logic        override_mode, override_mode_next;
  logic        latched_level, latched_level_next;
  logic        rx_led_level, rx_led_level_next;
  logic        tx_led_level, tx_led_level_next;

  logic        tx_have;
  logic [15:0] tx_word;
  logic [1:0]  cause;
  logic        bad;
  logic [15:0] rx_word;
  logic [7:0]  v;
  logic        rst_session;
  logic [1:0]  rst_cause;
  logic        done;

  // One step of the responder, worked through in the order of the protocol.
  always_comb begin
    session_phase_next   = session_phase;
    half_pending_next    = half_pending;
    half_word_next       = half_word;
    next_reply_next      = next_reply;
    zero_run_next        = zero_run;
    reply_wait_left_next = reply_wait_left;
    idle_left_next       = idle_left;
    rx_pulse_left_next   = rx_pulse_left;
    tx_pulse_left_next   = tx_pulse_left;
    override_mode_next   = override_mode;
    latched_level_next   = latched_level;
    rx_led_level_next    = rx_led_level;
    tx_led_level_next    = tx_led_level;
    tx_have     = 1'b0;
    tx_word     = '0;
    cause       = mlr_pkg::CauseNone;
    bad         = 1'b0;
    rst_session = 1'b0;
    rst_cause   = mlr_pkg::CauseNone;
    done        = 1'b0;
    rx_word     = {half_word, item.rx_byte};
    v           = mlr_pkg::mch_decode(rx_word);

    if (session_phase == mlr_pkg::PhaseBad) begin
      rst_session = 1'b1;
      rst_cause   = mlr_pkg::CauseNone;
    end else if (item.mode == mlr_pkg::ModeTick) begin
      // LED pulse timers count down and switch the LED off at zero.
      if (rx_pulse_left != '0) begin
        rx_pulse_left_next = rx_pulse_left - 16'd1;
        if (rx_pulse_left == 16'd1) rx_led_level_next = 1'b0;
      end
      if (tx_pulse_left != '0) begin
        tx_pulse_left_next = tx_pulse_left - 16'd1;
        if (tx_pulse_left == 16'd1) tx_led_level_next = 1'b0;
      end
      if (session_phase == mlr_pkg::PhaseWaitByte) begin
        if (idle_left <= 16'd1) begin
          rst_session = 1'b1;
          rst_cause   = mlr_pkg::CauseIdle;
        end else begin
          idle_left_next = idle_left - 16'd1;
        end
      end else if (session_phase == mlr_pkg::PhaseWaitReply) begin
        if (idle_left <= 16'd1) begin
          rst_session = 1'b1;
          rst_cause   = mlr_pkg::CauseReplyIdle;
        end else if (reply_wait_left <= 16'd1) begin
          // Reply delay has run out: send the next reply byte.
          reply_wait_left_next = '0;
          tx_have            = 1'b1;
          tx_word            = mlr_pkg::mch_encode(next_reply);
          half_pending_next  = 1'b0;
          if (!override_mode) begin
            tx_pulse_left_next = cfg.led_pulse_ms;
            tx_led_level_next  = |cfg.led_pulse_ms;
          end
          if (next_reply >= mlr_pkg::ReplyLast) next_reply_next = cfg.reply_first;
          else next_reply_next = next_reply + 8'd1;
          idle_left_next     = cfg.idle_timeout_ms;
          session_phase_next = mlr_pkg::PhaseWaitByte;
        end else begin
          idle_left_next       = idle_left - 16'd1;
          reply_wait_left_next = reply_wait_left - 16'd1;
        end
      end
    end else if (session_phase != mlr_pkg::PhaseWaitReply) begin
      if (!half_pending) begin
        half_word_next    = item.rx_byte;
        half_pending_next = 1'b1;
      end else begin
        half_pending_next = 1'b0;
        if (!mlr_pkg::mch_valid(rx_word)) begin
          bad = 1'b1;
        end else begin
          // A logical byte has arrived.
          if (!override_mode) begin
            rx_pulse_left_next = cfg.led_pulse_ms;
            rx_led_level_next  = |cfg.led_pulse_ms;
          end
          if (session_phase == mlr_pkg::PhaseWaitStart) begin
            if (v == cfg.open_code) begin
              tx_have            = 1'b1;
              tx_word            = mlr_pkg::mch_encode(cfg.ack_code);
              if (!override_mode) begin
                tx_pulse_left_next = cfg.led_pulse_ms;
                tx_led_level_next  = |cfg.led_pulse_ms;
              end
              idle_left_next     = cfg.idle_timeout_ms;
              zero_run_next      = '0;
              session_phase_next = mlr_pkg::PhaseWaitByte;
            end
            done = 1'b1;
          end
          if (!done) begin
            if (v == cfg.toggle_byte) begin
              override_mode_next = ~override_mode;
              latched_level_next = ~latched_level;
              rx_pulse_left_next = '0;
              tx_pulse_left_next = '0;
              rx_led_level_next  = ~latched_level;
              tx_led_level_next  = ~latched_level;
              zero_run_next      = '0;
            end
            if (v == 8'h00) begin
              // The toggle clears the run first, so count from its result.
              if (zero_run_next >= mlr_pkg::ZeroLimit - 2'd1) begin
                rst_session = 1'b1;
                rst_cause   = mlr_pkg::CauseZeros;
              end else begin
                zero_run_next = zero_run_next + 2'd1;
              end
            end else begin
              zero_run_next = '0;
            end
            if (!rst_session) begin
              reply_wait_left_next = cfg.reply_wait_ticks;
              idle_left_next       = cfg.idle_timeout_ms;
              session_phase_next   = mlr_pkg::PhaseWaitReply;
            end
          end
        end
      end
    end

    // Session reset back to waiting for start.
    if (rst_session) begin
      half_pending_next    = 1'b0;
      next_reply_next      = cfg.reply_first;
      reply_wait_left_next = '0;
      idle_left_next       = '0;
      zero_run_next        = '0;
      session_phase_next   = mlr_pkg::PhaseWaitStart;
      cause                = rst_cause;
    end
  end

  // State registers, advanced once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      session_phase   <= mlr_pkg::PhaseWaitStart;
      half_pending    <= 1'b0;
      half_word       <= '0;
      next_reply      <= mlr_pkg::ReplyFirstRst;
      zero_run        <= '0;
      reply_wait_left <= '0;
      idle_left       <= '0;
      rx_pulse_left   <= '0;
      tx_pulse_left   <= '0;
      override_mode   <= 1'b0;
      latched_level   <= 1'b0;
      rx_led_level    <= 1'b0;
      tx_led_level    <= 1'b0;
    end else if (go) begin
      session_phase   <= session_phase_next;
      half_pending    <= half_pending_next;
      half_word       <= half_word_next;
      next_reply      <= next_reply_next;
      zero_run        <= zero_run_next;
      reply_wait_left <= reply_wait_left_next;
      idle_left       <= idle_left_next;
      rx_pulse_left   <= rx_pulse_left_next;
      tx_pulse_left   <= tx_pulse_left_next;
      override_mode   <= override_mode_next;
      latched_level   <= latched_level_next;
      rx_led_level    <= rx_led_level_next;
      tx_led_level    <= tx_led_level_next;
    end
  end

  // Step outcome, with the LED levels as seen after the step.
  always_comb begin
    res.tx_have = tx_have;
    res.tx_word = tx_word;
    res.rx_led  = override_mode_next ? latched_level_next : rx_led_level_next;
    res.tx_led  = override_mode_next ? latched_level_next : tx_led_level_next;
    res.phase   = session_phase_next;
    res.cause   = cause;
    res.bad     = bad;
  end

endmodule

`default_nettype wire

>>> design/mlr_outq.sv
`default_nettype none

module mlr_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire mlr_pkg::step_res_t res_in,
  output logic                    can_load,
  output logic                    valid,
  input  wire logic               stall,
  output mlr_pkg::out_item_t      data
);

  logic               q_valid;
  logic               second;
  mlr_pkg::step_res_t res;
  logic               is_last;
  logic               fire;

  assign is_last  = !res.tx_have || second;
  assign fire     = q_valid && !stall;
  assign can_load = !q_valid || (fire && is_last);
  assign valid    = q_valid;

  // Result register: one step outcome, sent as one item or as two line bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      second  <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
      second  <= 1'b0;
    end else if (fire && !is_last) begin
      second <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_in;
  end

  // Output item fields.
  always_comb begin
    data.line_valid  = res.tx_have;
    data.line_byte   = !res.tx_have ? 8'h00 :
                       (second ? res.tx_word[7:0] : res.tx_word[15:8]);
    data.last        = is_last;
    data.rx_led      = res.rx_led;
    data.tx_led      = res.tx_led;
    data.phase       = res.phase;
    data.reset_cause = res.cause;
    data.bad_word    = res.bad;
  end

endmodule

`default_nettype wire

>>> design/manchester_link_responder.sv
`default_nettype none

// Session responder for a Manchester-coded byte link. Each input item is a
// millisecond tick or one raw line byte; line bytes pair into words that
// decode to logical bytes, and the responder answers a start byte with an
// acknowledge, then answers each received byte with the next reply byte after
// the reply delay. Every item gives one result item, or two when a byte is
// sent (high line byte, then low line byte, the second marked last). An item
// passes an input register, the step logic and a result register. A new item is
// taken every cycle while results drain, except that an item that sends a byte
// holds the result register until its second line byte has been taken.
// Configuration is written through the cfg port, which is always ready.
module manchester_link_responder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mlr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mlr_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  mlr_pkg::cfg_t      cfg;
  mlr_pkg::in_item_t  item;
  mlr_pkg::step_res_t res;
  logic               item_valid;
  logic               can_load;
  logic               step_go;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign step_go   = item_valid && can_load;
  assign in_stall  = item_valid && !can_load;
  assign accept    = in_valid && !in_stall;

  mlr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (step_go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
  end

  mlr_step u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (step_go),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  mlr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (step_go),
    .res_in   (res),
    .can_load (can_load),
    .valid    (out_valid),
    .stall    (out_stall),
    .data     (out_data)
  );

  // A first line byte is always followed by the matching last line byte.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.last && out_data.line_valid)
    else $error("second line byte missing");

  // Items that send nothing carry a zero byte and are single.
  a_idle_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.line_valid |-> out_data.line_byte == 8'h00 && out_data.last)
    else $error("empty item malformed");

  // The input register only stalls while it holds an item.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && !step_go)
    else $error("stall without held item");

  // The session never reports the unused phase code.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.phase != mlr_pkg::PhaseBad)
    else $error("unused phase reported");

endmodule

`default_nettype wire

>>> tb/tb_manchester_link_responder.sv
`default_nettype none

module tb_manchester_link_responder;

  localparam int RxLamp = 0;
  localparam int TxLamp = 1;
  localparam int LongHold = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  mlr_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  mlr_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  manchester_link_responder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Test control shared between the sender, the receiver and the checker.
  bit calm;
  bit hold_req;
  int fail_count;

  // Responder state as the testbench predicts it.
  mlr_pkg::cfg_t regs;
  logic [1:0] sess_phase;
  logic half_held;
  logic [7:0] held_byte;
  logic [7:0] reply_next;
  logic [1:0] zeros_seen;
  logic [15:0] reply_countdown;
  logic [15:0] idle_countdown;
  logic [15:0] glow_left [2];
  logic lamp [2];
  logic leds_latched;
  logic latch_level;

  // What the current item does, gathered while it is predicted.
  logic sending;
  logic [15:0] sent_word;
  logic [1:0] step_cause;
  logic step_bad;

  // Line results still owed by the block, oldest first.
  mlr_pkg::out_item_t line_results_due [$];
  mlr_pkg::out_item_t due;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Manchester line code of one byte, MSB first: 1 is 01 and 0 is 10.
  function automatic logic [15:0] line_code(input logic [7:0] v);
    logic [15:0] w;
    w = '0;
    for (int i = 7; i >= 0; i--) begin
      w = {w[13:0], (v[i] ? 2'b01 : 2'b10)};
    end
    return w;
  endfunction

  // Top bit says whether the word is clean Manchester; the low byte is its data.
  function automatic logic [8:0] line_decode(input logic [15:0] w);
    logic [8:0] r;
    r = 9'h100;
    for (int i = 7; i >= 0; i--) begin
      case (w[2*i +: 2])
        2'b01: r[i] = 1'b1;
        2'b10: r[i] = 1'b0;
        default: r[8] = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic mlr_pkg::in_item_t item_of(input logic m, input logic [7:0] b);
    mlr_pkg::in_item_t it;
    it.mode = m;
    it.rx_byte = b;
    return it;
  endfunction

  // An activity lights a lamp for the pulse length, unless the lamps are latched.
  task automatic lamp_pulse(input int k);
    if (!leds_latched) begin
      glow_left[k] = regs.led_pulse_ms;
      lamp[k] = (regs.led_pulse_ms != 16'd0);
    end
  endtask

  task automatic lamp_tick(input int k);
    if (glow_left[k] != 16'd0) begin
      glow_left[k]--;
      if (glow_left[k] == 16'd0) lamp[k] = 1'b0;
    end
  endtask

  // Sending a byte drops any half-word that was waiting for its partner.
  task automatic emit_byte(input logic [7:0] v);
    sending = 1'b1;
    sent_word = line_code(v);
    half_held = 1'b0;
    lamp_pulse(TxLamp);
  endtask

  task automatic restart_session(input logic [1:0] why);
    half_held = 1'b0;
    reply_next = regs.reply_first;
    reply_countdown = '0;
    idle_countdown = '0;
    zeros_seen = '0;
    sess_phase = mlr_pkg::PhaseWaitStart;
    step_cause = why;
  endtask

  // One decoded data byte reaches the session logic.
  task automatic take_byte(input logic [7:0] v);
    lamp_pulse(RxLamp);
    if (sess_phase == mlr_pkg::PhaseWaitStart) begin
      if (v == regs.open_code) begin
        emit_byte(regs.ack_code);
        idle_countdown = regs.idle_timeout_ms;
        zeros_seen = '0;
        sess_phase = mlr_pkg::PhaseWaitByte;
      end
    end else begin
      if (v == regs.toggle_byte) begin
        leds_latched = ~leds_latched;
        latch_level = ~latch_level;
        glow_left[RxLamp] = '0;
        glow_left[TxLamp] = '0;
        lamp[RxLamp] = latch_level;
        lamp[TxLamp] = latch_level;
        zeros_seen = '0;
      end
      if (v == 8'h00 && zeros_seen == mlr_pkg::ZeroLimit - 2'd1) begin
        restart_session(mlr_pkg::CauseZeros);
      end else begin
        zeros_seen = (v == 8'h00) ? zeros_seen + 2'd1 : 2'd0;
        reply_countdown = regs.reply_wait_ticks;
        idle_countdown = regs.idle_timeout_ms;
        sess_phase = mlr_pkg::PhaseWaitReply;
      end
    end
  endtask

  // A millisecond tick: lamps fade, and the idle timer wins over the reply timer.
  task automatic take_tick();
    lamp_tick(RxLamp);
    lamp_tick(TxLamp);
    if (sess_phase == mlr_pkg::PhaseWaitByte) begin
      if (idle_countdown <= 16'd1) restart_session(mlr_pkg::CauseIdle);
      else idle_countdown--;
    end else if (sess_phase == mlr_pkg::PhaseWaitReply) begin
      if (idle_countdown <= 16'd1) begin
        restart_session(mlr_pkg::CauseReplyIdle);
      end else begin
        idle_countdown--;
        if (reply_countdown <= 16'd1) begin
          reply_countdown = '0;
          emit_byte(reply_next);
          reply_next = (reply_next >= mlr_pkg::ReplyLast) ? regs.reply_first
                                                          : reply_next + 8'd1;
          idle_countdown = regs.idle_timeout_ms;
          sess_phase = mlr_pkg::PhaseWaitByte;
        end else begin
          reply_countdown--;
        end
      end
    end
  endtask

  // Works out the one or two line results owed for an accepted item.
  task automatic respond_to_item(input mlr_pkg::in_item_t it);
    mlr_pkg::out_item_t r;
    logic [8:0] dec;
    int n;
    sending = 1'b0;
    step_cause = mlr_pkg::CauseNone;
    step_bad = 1'b0;
    if (it.mode == mlr_pkg::ModeTick) begin
      take_tick();
    end else if (sess_phase != mlr_pkg::PhaseWaitReply) begin
      if (!half_held) begin
        held_byte = it.rx_byte;
        half_held = 1'b1;
      end else begin
        half_held = 1'b0;
        dec = line_decode({held_byte, it.rx_byte});
        if (dec[8]) take_byte(dec[7:0]);
        else step_bad = 1'b1;
      end
    end
    n = sending ? 2 : 1;
    for (int k = 0; k < n; k++) begin
      r.line_valid = sending;
      r.line_byte = !sending ? 8'h00 : (k == 0) ? sent_word[15:8] : sent_word[7:0];
      r.last = (k == n - 1);
      r.rx_led = leds_latched ? latch_level : lamp[RxLamp];
      r.tx_led = leds_latched ? latch_level : lamp[TxLamp];
      r.phase = sess_phase;
      r.reset_cause = step_cause;
      r.bad_word = step_bad;
      line_results_due.push_back(r);
    end
  endtask

  // Offers one item, after a random gap now and then, and predicts it on acceptance.
  task automatic send_item(input mlr_pkg::in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    respond_to_item(it);
  endtask

  task automatic send_tick();
    send_item(item_of(mlr_pkg::ModeTick, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_item(item_of(mlr_pkg::ModeByte, b));
  endtask

  // A data byte goes out on the line as two raw bytes, high half first.
  task automatic send_logical(input logic [7:0] v);
    logic [15:0] w;
    w = line_code(v);
    send_raw(w[15:8]);
    send_raw(w[7:0]);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input mlr_pkg::cfg_reg_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mlr_pkg::REG_START_BYTE:   regs.open_code = v[7:0];
      mlr_pkg::REG_ACK_BYTE:     regs.ack_code = v[7:0];
      mlr_pkg::REG_TOGGLE_BYTE:  regs.toggle_byte = v[7:0];
      mlr_pkg::REG_REPLY_FIRST:  regs.reply_first = v[7:0];
      mlr_pkg::REG_REPLY_DELAY:  regs.reply_wait_ticks = v;
      mlr_pkg::REG_IDLE_TIMEOUT: regs.idle_timeout_ms = v;
      mlr_pkg::REG_LED_PULSE:    regs.led_pulse_ms = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Rewrites every register once the block has gone quiet.
  task automatic set_config(input logic [7:0] start_b, input logic [7:0] ack_b,
                            input logic [7:0] toggle_b, input logic [7:0] first_b,
                            input logic [15:0] delay_t, input logic [15:0] idle_t,
                            input logic [15:0] pulse_t);
    drain();
    write_reg(mlr_pkg::REG_START_BYTE, {8'h00, start_b});
    write_reg(mlr_pkg::REG_ACK_BYTE, {8'h00, ack_b});
    write_reg(mlr_pkg::REG_TOGGLE_BYTE, {8'h00, toggle_b});
    write_reg(mlr_pkg::REG_REPLY_FIRST, {8'h00, first_b});
    write_reg(mlr_pkg::REG_REPLY_DELAY, delay_t);
    write_reg(mlr_pkg::REG_IDLE_TIMEOUT, idle_t);
    write_reg(mlr_pkg::REG_LED_PULSE, pulse_t);
  endtask

  // One random step of line traffic, mostly well-formed. Returns how many items
  // reached the block's logic rather than being dropped while a reply is due.
  task automatic random_step(output int useful);
    int pick;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    useful = 0;
    if (sess_phase == mlr_pkg::PhaseWaitReply && pick >= 15) pick = 0;
    if (pick < 40) begin
      send_tick();
      useful = 1;
    end else if (pick < 85) begin
      if (half_held && $urandom_range(0, 2) != 0) begin
        send_raw(8'($urandom_range(0, 255)));
        useful = 1;
      end
      case ($urandom_range(0, 5))
        0, 1: v = regs.open_code;
        2: v = regs.toggle_byte;
        3: v = 8'h00;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if (sess_phase != mlr_pkg::PhaseWaitReply) useful += 2;
      send_logical(v);
    end else if (pick < 93) begin
      if (sess_phase != mlr_pkg::PhaseWaitReply) useful = 1;
      send_raw(8'($urandom_range(0, 255)));
    end else begin
      // Two raw bytes whose pairing breaks the line code.
      if (sess_phase != mlr_pkg::PhaseWaitReply) useful = 2;
      send_raw(8'($urandom_range(0, 255)));
      send_raw(8'($urandom_range(0, 255)) | 8'h03);
    end
  endtask

  task automatic random_run(input int n);
    int done;
    int got;
    done = 0;
    while (done < n) begin
      random_step(got);
      done += got;
    end
  endtask

  // Start, acknowledge, replies, bad words, three zeros and the idle timeout.
  task automatic test_session_flow();
    set_config(8'hA5, 8'h00, 8'hFF, 8'hBF, 16'd0, 16'd2, 16'd1);
    send_raw(8'h00);
    send_raw(8'h00);
    send_logical(8'h3C);
    send_logical(8'hA5);
    send_logical(8'h00);
    send_tick();
    send_logical(8'h00);
    send_tick();
    send_logical(8'h00);
    send_logical(8'hA5);
    send_raw(8'hFF);
    send_tick();
    send_tick();
  endtask

  // Widest timers, a toggle byte of zero, bytes ignored while a reply is due,
  // and the idle timer expiring while the reply timer is still running.
  task automatic test_timer_extremes();
    set_config(8'h00, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'd1, 16'hFFFF);
    send_logical(8'h00);
    send_logical(8'h00);
    send_raw(8'hFF);
    send_tick();
  endtask

  // A reply start above the top of the sequence, loaded by a session reset and again on wrap.
  task automatic test_reply_first_high();
    set_config(8'h3C, 8'h99, 8'h10, 8'hC5, 16'd1, 16'd2, 16'd0);
    send_logical(8'h3C);
    send_tick();
    send_tick();
    send_logical(8'h3C);
    send_logical(8'h10);
    send_tick();
    send_logical(8'h22);
    send_tick();
  endtask

  // The receiver holds off for a long stretch while items keep arriving.
  task automatic test_backpressure();
    set_config(8'h5A, 8'hC3, 8'h81, 8'hB8, 16'd2, 16'd10, 16'd3);
    calm = 1'b1;
    hold_req = 1'b1;
    random_run(60);
    calm = 1'b0;
  endtask

  // Random traffic over several register settings.
  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [7:0] first_b;
    for (int p = 0; p < phases; p++) begin
      first_b = (p == 0) ? mlr_pkg::ReplyLast :
                (p == 1) ? 8'h00 : 8'($urandom_range(0, 191));
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), first_b,
                 16'($urandom_range(0, 6)), 16'($urandom_range(1, 12)),
                 16'($urandom_range(0, 4)));
      random_run(per_phase);
    end
  endtask

  // Last stretch with no gaps and no stalls on either side.
  task automatic test_quiet_finish();
    set_config(8'hE7, 8'h18, 8'h66, 8'hA0, 16'd3, 16'd8, 16'd2);
    calm = 1'b1;
    random_run(110);
  endtask

  // Result side: random stall bursts, and one long hold when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Each accepted result is compared with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (line_results_due.size() == 0) begin
        $display("%0t: no result expected, got %h", $time, out_data);
        fail_count++;
      end else begin
        due = line_results_due.pop_front();
        check_field("line_valid", 16'(due.line_valid), 16'(out_data.line_valid));
        check_field("line_byte", 16'(due.line_byte), 16'(out_data.line_byte));
        check_field("last", 16'(due.last), 16'(out_data.last));
        check_field("rx_led", 16'(due.rx_led), 16'(out_data.rx_led));
        check_field("tx_led", 16'(due.tx_led), 16'(out_data.tx_led));
        check_field("phase", 16'(due.phase), 16'(out_data.phase));
        check_field("reset_cause", 16'(due.reset_cause), 16'(out_data.reset_cause));
        check_field("bad_word", 16'(due.bad_word), 16'(out_data.bad_word));
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("manchester_link_responder: mismatch");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;

    // Predicted state straight after reset.
    regs = '{open_code: mlr_pkg::StartByteRst, ack_code: mlr_pkg::AckByteRst,
             toggle_byte: mlr_pkg::ToggleByteRst, reply_first: mlr_pkg::ReplyFirstRst,
             reply_wait_ticks: mlr_pkg::ReplyDelayRst,
             idle_timeout_ms: mlr_pkg::IdleTimeoutRst,
             led_pulse_ms: mlr_pkg::LedPulseRst};
    sess_phase = mlr_pkg::PhaseWaitStart;
    half_held = 1'b0;
    held_byte = '0;
    reply_next = mlr_pkg::ReplyFirstRst;
    zeros_seen = '0;
    reply_countdown = '0;
    idle_countdown = '0;
    glow_left[RxLamp] = '0;
    glow_left[TxLamp] = '0;
    lamp[RxLamp] = 1'b0;
    lamp[TxLamp] = 1'b0;
    leds_latched = 1'b0;
    latch_level = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_session_flow();
    test_timer_extremes();
    test_reply_first_high();
    test_backpressure();
    test_random_traffic(6, 225);
    test_quiet_finish();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("manchester_link_responder: match");
    end else begin
      $display("manchester_link_responder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> manchester_link_responder.f
design/mlr_pkg.sv
design/mlr_cfg.sv
design/mlr_step.sv
design/mlr_outq.sv
design/manchester_link_responder.sv
tb/tb_manchester_link_responder.sv
